// File: hw/rtl/aie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aie_pkg;

	// Opcode bytes of the supported subset
	localparam logic [7:0] OPC_NOP    = 8'h00;
	localparam logic [7:0] OPC_LD_IMM = 8'h3E;
	localparam logic [7:0] OPC_INC_A  = 8'h3C;
	localparam logic [7:0] OPC_DEC_A  = 8'h3D;
	localparam logic [7:0] OPC_ADD    = 8'hC6;
	localparam logic [7:0] OPC_SUB    = 8'hD6;
	localparam logic [7:0] OPC_XOR_A  = 8'hAF;

	// Cycle costs
	localparam logic [1:0] COST_NONE  = 2'd0;
	localparam logic [1:0] COST_ONE   = 2'd1;
	localparam logic [1:0] COST_TWO   = 2'd2;

	typedef enum logic [2:0] {
		CLS_NOP,
		CLS_LD,
		CLS_INC,
		CLS_DEC,
		CLS_ADD,
		CLS_SUB,
		CLS_XOR,
		CLS_UNK
	} op_class_t;

	// Decoded request handed from front to back
	typedef struct packed {
		op_class_t  cls;
		logic [7:0] imm;
		logic       two_byte;
		logic [1:0] cost;
	} dec_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/aie_front.sv
`timescale 1ns / 1ps
`default_nettype none

module aie_front
	import aie_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic [7:0] opcode,
	input  wire logic [7:0] immediate_byte,
	output logic            dec_valid,
	input  wire logic       dec_ready,
	output dec_req_t        dec_req
);

	dec_req_t dec_d;
	dec_req_t dec_s1;
	logic     valid_s1;

	always_comb begin
		dec_d.imm      = immediate_byte;
		dec_d.two_byte = 1'b0;
		dec_d.cost     = COST_ONE;
		unique case (opcode)
			OPC_NOP:    dec_d.cls = CLS_NOP;
			OPC_LD_IMM: begin
				dec_d.cls      = CLS_LD;
				dec_d.two_byte = 1'b1;
				dec_d.cost     = COST_TWO;
			end
			OPC_INC_A:  dec_d.cls = CLS_INC;
			OPC_DEC_A:  dec_d.cls = CLS_DEC;
			OPC_ADD:    begin
				dec_d.cls      = CLS_ADD;
				dec_d.two_byte = 1'b1;
				dec_d.cost     = COST_TWO;
			end
			OPC_SUB:    begin
				dec_d.cls      = CLS_SUB;
				dec_d.two_byte = 1'b1;
				dec_d.cost     = COST_TWO;
			end
			OPC_XOR_A:  dec_d.cls = CLS_XOR;
			default:    begin
				dec_d.cls  = CLS_UNK;
				dec_d.cost = COST_NONE;
			end
		endcase
	end

	assign req_ready = !valid_s1 || dec_ready;
	assign dec_valid = valid_s1;
	assign dec_req   = dec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			dec_s1 <= dec_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/aie_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module aie_queue
	import aie_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire dec_req_t in_req,
	output logic          out_valid,
	input  wire logic     out_ready,
	output dec_req_t      out_req
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	dec_req_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign in_ready  = count_q != CW'(DEPTH);
	assign out_valid = count_q != '0;
	assign out_req   = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_req;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/aie_back.sv
`timescale 1ns / 1ps
`default_nettype none

module aie_back
	import aie_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        dec_valid,
	output logic             dec_ready,
	input  wire dec_req_t    dec_req,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [7:0]       accumulator_value,
	output logic             zero_flag,
	output logic             subtract_flag,
	output logic             half_carry_flag,
	output logic             carry_flag,
	output logic [15:0]      next_pc,
	output logic [1:0]       cycles_taken,
	output logic             unimplemented,
	output logic [31:0]      total_cycles
);

	// Architectural state doubles as the result register: it only moves
	// when the previous result has been taken.
	logic [7:0]  acc_q;
	logic        z_q, n_q, h_q, c_q;
	logic [15:0] pc_q;
	logic [31:0] total_q;
	logic [1:0]  cost_q;
	logic        unimpl_q;
	logic        rsp_valid_q;

	logic        exec;
	logic [7:0]  acc_d;
	logic        z_d, n_d, h_d, c_d;
	logic [8:0]  sum9;
	logic [8:0]  diff9;
	logic [4:0]  sum_lo;

	assign dec_ready = !rsp_valid_q || rsp_ready;
	assign exec      = dec_valid && dec_ready;

	assign sum9   = {1'b0, acc_q} + {1'b0, dec_req.imm};
	assign diff9  = {1'b0, acc_q} - {1'b0, dec_req.imm};
	assign sum_lo = {1'b0, acc_q[3:0]} + {1'b0, dec_req.imm[3:0]};

	always_comb begin
		acc_d = acc_q;
		z_d   = z_q;
		n_d   = n_q;
		h_d   = h_q;
		c_d   = c_q;
		unique case (dec_req.cls)
			CLS_LD:  acc_d = dec_req.imm;
			CLS_INC: begin
				acc_d = acc_q + 8'd1;
				z_d   = acc_d == 8'h00;
				n_d   = 1'b0;
				h_d   = acc_q[3:0] == 4'hF;
			end
			CLS_DEC: begin
				acc_d = acc_q - 8'd1;
				z_d   = acc_d == 8'h00;
				n_d   = 1'b1;
				h_d   = acc_q[3:0] == 4'h0;
			end
			CLS_ADD: begin
				acc_d = sum9[7:0];
				z_d   = sum9[7:0] == 8'h00;
				n_d   = 1'b0;
				h_d   = sum_lo[4];
				c_d   = sum9[8];
			end
			CLS_SUB: begin
				acc_d = diff9[7:0];
				z_d   = diff9[7:0] == 8'h00;
				n_d   = 1'b1;
				h_d   = acc_q[3:0] < dec_req.imm[3:0];
				c_d   = diff9[8];
			end
			CLS_XOR: begin
				acc_d = 8'h00;
				z_d   = 1'b1;
				n_d   = 1'b0;
				h_d   = 1'b0;
				c_d   = 1'b0;
			end
			default: ; // NOP and unknown opcodes leave A and flags alone
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			z_q         <= 1'b0;
			n_q         <= 1'b0;
			h_q         <= 1'b0;
			c_q         <= 1'b0;
			pc_q        <= '0;
			total_q     <= '0;
			cost_q      <= COST_NONE;
			unimpl_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (dec_ready) begin
				rsp_valid_q <= dec_valid;
			end
			if (exec) begin
				acc_q    <= acc_d;
				z_q      <= z_d;
				n_q      <= n_d;
				h_q      <= h_d;
				c_q      <= c_d;
				pc_q     <= pc_q + (dec_req.two_byte ? 16'd2 : 16'd1);
				total_q  <= total_q + {30'd0, dec_req.cost};
				cost_q   <= dec_req.cost;
				unimpl_q <= dec_req.cls == CLS_UNK;
			end
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign accumulator_value = acc_q;
	assign zero_flag         = z_q;
	assign subtract_flag     = n_q;
	assign half_carry_flag   = h_q;
	assign carry_flag        = c_q;
	assign next_pc           = pc_q;
	assign cycles_taken      = cost_q;
	assign unimplemented     = unimpl_q;
	assign total_cycles      = total_q;

endmodule

`default_nettype wire

// File: hw/rtl/accumulator_instruction_executor_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Executes a small accumulator instruction subset (NOP, LD A,imm, INC A,
// DEC A, ADD A,imm, SUB imm, XOR A) one request at a time and returns the
// architectural state after each: A, the Z/N/H/C flags, the next PC, the
// cycle cost and a 32-bit wrapping cycle total. Any other opcode advances
// the PC by one, costs nothing and sets unimplemented. A new request is
// accepted every clock cycle unless the queue is full and the result
// side stalls; a request passes the decode register, the queue and the
// execute/result register, waiting longer while the result side stalls.
// A QUEUE_DEPTH-entry queue parts the front decode and back execute
// stages, and the execute loop (8-bit add plus flags) sets the rate.

module accumulator_instruction_executor_core
	import aie_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2   // queue entries, 1 or more
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request side
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [7:0]  opcode,
	input  wire logic [7:0]  immediate_byte,
	// result side
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [7:0]       accumulator_value,
	output logic             zero_flag,
	output logic             subtract_flag,
	output logic             half_carry_flag,
	output logic             carry_flag,
	output logic [15:0]      next_pc,
	output logic [1:0]       cycles_taken,
	output logic             unimplemented,
	output logic [31:0]      total_cycles
);

	// front -> queue
	logic     fq_valid;
	logic     fq_ready;
	dec_req_t fq_req;
	// queue -> back
	logic     qb_valid;
	logic     qb_ready;
	dec_req_t qb_req;

	// Decode: opcode classified into an op class, length and cost
	aie_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.opcode         (opcode),
		.immediate_byte (immediate_byte),
		.dec_valid      (fq_valid),
		.dec_ready      (fq_ready),
		.dec_req        (fq_req)
	);

	// Decoupling queue: lets decode keep taking requests while results stall
	aie_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_req    (fq_req),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_req   (qb_req)
	);

	// Execute: owns A, flags, PC and cycle total; state is the result register
	aie_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.dec_valid         (qb_valid),
		.dec_ready         (qb_ready),
		.dec_req           (qb_req),
		.rsp_valid         (rsp_valid),
		.rsp_ready         (rsp_ready),
		.accumulator_value (accumulator_value),
		.zero_flag         (zero_flag),
		.subtract_flag     (subtract_flag),
		.half_carry_flag   (half_carry_flag),
		.carry_flag        (carry_flag),
		.next_pc           (next_pc),
		.cycles_taken      (cycles_taken),
		.unimplemented     (unimplemented),
		.total_cycles      (total_cycles)
	);

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the accumulator instruction executor.
//
// Requests (opcode + immediate byte) are queued up front by an initial block and
// handed to the block by a clocked driver. The driver inserts a random gap before
// each request, and every so often it holds off until all outstanding responses
// are back. A clocked monitor drops rsp_ready for a random number of cycles after
// each response. Some stretches run with no gaps and no stalls.
//
// A shadow copy of A, the flags, the PC and the cycle total is stepped every time
// a request is accepted. The result is queued, and each response is checked field
// by field against the oldest queued entry.

module tb_top;
	import aie_pkg::*;

	localparam int unsigned RANDOM_REQS = 1880;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_WAIT  = 8;       // decode register, queue and result register, plus margin

	// Request waiting to be driven
	typedef struct {
		logic [7:0]  opc;
		logic [7:0]  imm;
		int unsigned gap;     // idle cycles before the request is presented
		bit          drain;   // hold off until nothing is outstanding
	} instr_req_t;

	// Architectural state the block reports after each instruction
	typedef struct packed {
		logic [7:0]  a;
		logic        z;
		logic        n;
		logic        h;
		logic        c;
		logic [15:0] pc;
		logic [1:0]  cost;
		logic        unimpl;
		logic [31:0] total;
	} arch_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [7:0]  opcode = 8'h00;
	logic [7:0]  immediate_byte = 8'h00;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [7:0]  accumulator_value;
	logic        zero_flag;
	logic        subtract_flag;
	logic        half_carry_flag;
	logic        carry_flag;
	logic [15:0] next_pc;
	logic [1:0]  cycles_taken;
	logic        unimplemented;
	logic [31:0] total_cycles;

	accumulator_instruction_executor_core u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (req_valid),
		.req_ready         (req_ready),
		.opcode            (opcode),
		.immediate_byte    (immediate_byte),
		.rsp_valid         (rsp_valid),
		.rsp_ready         (rsp_ready),
		.accumulator_value (accumulator_value),
		.zero_flag         (zero_flag),
		.subtract_flag     (subtract_flag),
		.half_carry_flag   (half_carry_flag),
		.carry_flag        (carry_flag),
		.next_pc           (next_pc),
		.cycles_taken      (cycles_taken),
		.unimplemented     (unimplemented),
		.total_cycles      (total_cycles)
	);

	instr_req_t  instr_fifo[$];      // requests not yet presented
	arch_state_t arch_expect_q[$];   // predicted responses, oldest first
	int unsigned err_count = 0;
	int unsigned cycle_count = 0;
	int unsigned rsp_count = 0;

	// Shadow architectural state
	logic [7:0]  shadow_a = 8'h00;
	logic        shadow_z = 1'b0;
	logic        shadow_n = 1'b0;
	logic        shadow_h = 1'b0;
	logic        shadow_c = 1'b0;
	logic [15:0] shadow_pc = 16'h0000;
	logic [31:0] shadow_total = 32'h0;

	// Driver and monitor scratch, each written by one always block only
	bit          drv_valid_nxt;
	int unsigned gap_cnt = 0;
	bit          mon_ready_nxt;
	int unsigned stall_left = 0;
	int unsigned stall_draw;
	arch_state_t exp_rsp;

	initial begin
		forever #1 clk = ~clk;
	end

	// Execute one instruction on the shadow state and queue what the block must return
	task automatic retire_instr(input logic [7:0] opc, input logic [7:0] imm);
		logic [8:0]  sum;
		logic [7:0]  old_a;
		logic        is_two_byte;
		logic [1:0]  cost;
		logic        unknown;
		arch_state_t st;
		old_a = shadow_a;
		is_two_byte = 1'b0;
		cost = COST_ONE;
		unknown = 1'b0;
		case (opc)
			OPC_NOP: begin
			end
			OPC_LD_IMM: begin
				// flags untouched by a load
				shadow_a = imm;
				is_two_byte = 1'b1;
				cost = COST_TWO;
			end
			OPC_INC_A: begin
				// carry survives INC/DEC
				shadow_a = old_a + 8'd1;
				shadow_z = (shadow_a == 8'h00);
				shadow_n = 1'b0;
				shadow_h = (old_a[3:0] == 4'hF);
			end
			OPC_DEC_A: begin
				shadow_a = old_a - 8'd1;
				shadow_z = (shadow_a == 8'h00);
				shadow_n = 1'b1;
				shadow_h = (old_a[3:0] == 4'h0);
			end
			OPC_ADD: begin
				sum = {1'b0, old_a} + {1'b0, imm};
				shadow_a = sum[7:0];
				shadow_z = (sum[7:0] == 8'h00);
				shadow_n = 1'b0;
				shadow_h = (({1'b0, old_a[3:0]} + {1'b0, imm[3:0]}) > 5'h0F);
				shadow_c = sum[8];
				is_two_byte = 1'b1;
				cost = COST_TWO;
			end
			OPC_SUB: begin
				shadow_a = old_a - imm;
				shadow_z = (shadow_a == 8'h00);
				shadow_n = 1'b1;
				shadow_h = (old_a[3:0] < imm[3:0]);
				shadow_c = (old_a < imm);
				is_two_byte = 1'b1;
				cost = COST_TWO;
			end
			OPC_XOR_A: begin
				shadow_a = 8'h00;
				shadow_z = 1'b1;
				shadow_n = 1'b0;
				shadow_h = 1'b0;
				shadow_c = 1'b0;
			end
			default: begin
				// unsupported: one-byte step, no cost, nothing else moves
				cost = COST_NONE;
				unknown = 1'b1;
			end
		endcase
		shadow_pc = shadow_pc + (is_two_byte ? 16'd2 : 16'd1);
		shadow_total = shadow_total + {30'd0, cost};
		st.a = shadow_a;
		st.z = shadow_z;
		st.n = shadow_n;
		st.h = shadow_h;
		st.c = shadow_c;
		st.pc = shadow_pc;
		st.cost = cost;
		st.unimpl = unknown;
		st.total = shadow_total;
		arch_expect_q.push_back(st);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_count++;
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	task automatic queue_instr(input logic [7:0] opc, input logic [7:0] imm,
			input int unsigned gap, input bit drain);
		instr_req_t r;
		r.opc = opc;
		r.imm = imm;
		r.gap = gap;
		r.drain = drain;
		instr_fifo.push_back(r);
	endtask

	// Immediates lean toward the nibble and byte edges now and then
	function automatic logic [7:0] pick_imm();
		logic [7:0] edges[8];
		edges = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'hF0, 8'hFF};
		if ($urandom_range(0, 3) == 0)
			return edges[$urandom_range(0, 7)];
		return 8'($urandom_range(0, 255));
	endfunction

	// Fill the request queue: directed corners first, then random traffic
	initial begin
		logic [7:0]  supported[7];
		logic [7:0]  opc;
		int unsigned gap;
		supported = '{OPC_NOP, OPC_LD_IMM, OPC_INC_A, OPC_DEC_A, OPC_ADD, OPC_SUB,
			OPC_XOR_A};

		// Directed: flag corners, wraparound of A, carry kept through INC/DEC,
		// immediate ignored on one-byte opcodes, unsupported opcodes
		queue_instr(OPC_NOP,    8'hFF, 0, 1'b0);  // stray immediate on NOP
		queue_instr(OPC_XOR_A,  8'h55, 1, 1'b0);
		queue_instr(OPC_LD_IMM, 8'hFF, 0, 1'b0);
		queue_instr(OPC_INC_A,  8'hA5, 2, 1'b0);  // FF -> 00: Z and H
		queue_instr(OPC_DEC_A,  8'h00, 0, 1'b0);  // 00 -> FF: half borrow
		queue_instr(OPC_ADD,    8'h01, 0, 1'b0);  // FF + 01: Z, H, C
		queue_instr(OPC_INC_A,  8'h00, 3, 1'b0);  // C stays set
		queue_instr(OPC_DEC_A,  8'hFF, 0, 1'b0);  // back to zero, C still set
		queue_instr(OPC_SUB,    8'h01, 0, 1'b0);  // 00 - 01: borrow both ways
		queue_instr(OPC_ADD,    8'hFF, 4, 1'b0);  // FF + FF
		queue_instr(OPC_LD_IMM, 8'h0F, 0, 1'b0);
		queue_instr(OPC_ADD,    8'h01, 0, 1'b0);  // nibble carry only
		queue_instr(OPC_SUB,    8'h10, 1, 1'b0);  // exact zero, no borrow
		queue_instr(OPC_SUB,    8'h00, 0, 1'b0);
		queue_instr(OPC_LD_IMM, 8'h80, 0, 1'b0);
		queue_instr(OPC_SUB,    8'h81, 0, 1'b0);  // byte and nibble borrow
		queue_instr(8'hFF,      8'h00, 2, 1'b0);  // unsupported
		queue_instr(8'h01,      8'hAA, 0, 1'b0);
		queue_instr(8'h0F,      8'h0F, 0, 1'b0);
		queue_instr(OPC_ADD,    8'h00, 0, 1'b0);
		queue_instr(OPC_XOR_A,  8'hFF, 0, 1'b0);
		queue_instr(OPC_DEC_A,  8'h00, 0, 1'b0);

		for (int unsigned i = 0; i < RANDOM_REQS; i++) begin
			if ($urandom_range(0, 99) < 15)
				opc = 8'($urandom_range(0, 255));
			else
				opc = supported[$urandom_range(0, 6)];
			// two back-to-back stretches with no sender gaps
			if ((i >= 400 && i < 600) || (i >= 1200 && i < 1350))
				gap = 0;
			else
				gap = $urandom_range(0, 4);
			// hold-off points: wait for the pipe to run dry before going on
			queue_instr(opc, pick_imm(), gap, (i == 0) || (i == 700) || (i == 1500));
		end
	end

	// Reset once, then wait for everything to be accepted and answered
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// checked between edges so driver and monitor updates have settled
		while (instr_fifo.size() != 0 || req_valid || arch_expect_q.size() != 0)
			@(negedge clk);
		// let any stray response surface
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[%0t] timeout after %0d cycles", $time, cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Request driver: valid is computed once per edge and assigned once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			opcode <= 8'h00;
			immediate_byte <= 8'h00;
			gap_cnt = 0;
		end else begin
			drv_valid_nxt = req_valid;
			if (req_valid && req_ready) begin
				retire_instr(opcode, immediate_byte);
				drv_valid_nxt = 1'b0;
			end
			if (!drv_valid_nxt && instr_fifo.size() != 0
					&& !(instr_fifo[0].drain && arch_expect_q.size() != 0)) begin
				if (gap_cnt < instr_fifo[0].gap) begin
					gap_cnt++;
				end else begin
					opcode <= instr_fifo[0].opc;
					immediate_byte <= instr_fifo[0].imm;
					drv_valid_nxt = 1'b1;
					gap_cnt = 0;
					void'(instr_fifo.pop_front());
				end
			end
			req_valid <= drv_valid_nxt;
		end
	end

	// Response monitor: check each accepted response, then maybe stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
		end else begin
			mon_ready_nxt = rsp_ready;
			if (rsp_valid && rsp_ready) begin
				if (arch_expect_q.size() == 0) begin
					report_mismatch("response with nothing pending", {24'd0, accumulator_value},
						32'd0);
				end else begin
					exp_rsp = arch_expect_q.pop_front();
					if (accumulator_value !== exp_rsp.a)
						report_mismatch("accumulator_value", 32'(accumulator_value),
							32'(exp_rsp.a));
					if (zero_flag !== exp_rsp.z)
						report_mismatch("zero_flag", 32'(zero_flag), 32'(exp_rsp.z));
					if (subtract_flag !== exp_rsp.n)
						report_mismatch("subtract_flag", 32'(subtract_flag), 32'(exp_rsp.n));
					if (half_carry_flag !== exp_rsp.h)
						report_mismatch("half_carry_flag", 32'(half_carry_flag),
							32'(exp_rsp.h));
					if (carry_flag !== exp_rsp.c)
						report_mismatch("carry_flag", 32'(carry_flag), 32'(exp_rsp.c));
					if (next_pc !== exp_rsp.pc)
						report_mismatch("next_pc", 32'(next_pc), 32'(exp_rsp.pc));
					if (cycles_taken !== exp_rsp.cost)
						report_mismatch("cycles_taken", 32'(cycles_taken), 32'(exp_rsp.cost));
					if (unimplemented !== exp_rsp.unimpl)
						report_mismatch("unimplemented", 32'(unimplemented),
							32'(exp_rsp.unimpl));
					if (total_cycles !== exp_rsp.total)
						report_mismatch("total_cycles", total_cycles, exp_rsp.total);
				end
				rsp_count++;
				// stall windows alternate with stretches of full throughput
				stall_draw = ((rsp_count % 500) < 350) ? $urandom_range(0, 4) : 0;
				if (stall_draw != 0) begin
					mon_ready_nxt = 1'b0;
					stall_left = stall_draw;
				end
			end else if (!rsp_ready) begin
				if (stall_left <= 1) begin
					mon_ready_nxt = 1'b1;
					stall_left = 0;
				end else begin
					stall_left--;
				end
			end
			rsp_ready <= mon_ready_nxt;
		end
	end

endmodule

// File: accumulator_instruction_executor_core.f
hw/rtl/aie_pkg.sv
hw/rtl/aie_front.sv
hw/rtl/aie_queue.sv
hw/rtl/aie_back.sv
hw/rtl/accumulator_instruction_executor_core.sv
verif/tb_top.sv
